// ===== hdl/ttrc_pkg.sv =====
// Shared widths and constants for the three-term recurrence checksum.
package ttrc_pkg;

  // Field and state widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TERM_W = 16;
  localparam int unsigned POS_W  = 8;

  // Coefficient steps per byte position, and the offset taken by a first byte.
  localparam logic [POS_W-1:0]  ALPHA_STEP   = 8'd17;
  localparam logic [POS_W-1:0]  BETA_STEP    = 8'd31;
  localparam logic [TERM_W-1:0] START_OFFSET = 16'd7;

  // Terms are reduced modulo 2^16 - 1.
  localparam logic [TERM_W:0]   TERM_MOD     = 17'd65535;

endpackage

// ===== hdl/ttrc_step.sv =====
// Next-term arithmetic of the recurrence: two products, a difference and a mod 65535 fold.
module ttrc_step (
  input  logic [ttrc_pkg::BYTE_W-1:0] data_byte,
  input  logic [ttrc_pkg::POS_W-1:0]  pos,
  input  logic [ttrc_pkg::TERM_W-1:0] newer_term,
  input  logic [ttrc_pkg::TERM_W-1:0] older_term,
  output logic [ttrc_pkg::TERM_W-1:0] next_term
);
  import ttrc_pkg::*;

  logic [POS_W-1:0]  alpha;
  logic [POS_W-1:0]  beta;
  logic [POS_W:0]    coef;
  logic [24:0]       plus;
  logic [24:0]       minus;
  logic              plus_ge;
  logic [24:0]       diff;
  logic [TERM_W:0]   fold;
  logic [TERM_W-1:0] red;
  logic [TERM_W-1:0] neg_term;

  // Position-dependent coefficients, both taken modulo 256.
  assign alpha = POS_W'(pos * ALPHA_STEP);
  assign beta  = POS_W'(pos * BETA_STEP);
  assign coef  = {1'b0, data_byte} + {1'b0, alpha};

  // The two products and the magnitude of their difference.
  assign plus    = 25'(coef) * 25'(newer_term);
  assign minus   = 25'(beta) * 25'(older_term);
  assign plus_ge = (plus >= minus);
  assign diff    = plus_ge ? (plus - minus) : (minus - plus);

  // Since 2^16 is 1 modulo 65535, the high bits fold onto the low half; one
  // conditional subtraction then finishes the reduction.
  assign fold = {1'b0, diff[TERM_W-1:0]} + 17'(diff[24:TERM_W]);
  assign red  = (fold >= TERM_MOD) ? TERM_W'(fold - TERM_MOD) : fold[TERM_W-1:0];

  // A negative difference follows the unsigned wrap: (65536 - d) mod 65535.
  assign neg_term  = (red <= 16'd1) ? (16'd1 - red) : (16'd0 - red);
  assign next_term = plus_ge ? red : neg_term;

endmodule

// ===== hdl/three_term_recurrence_checksum.sv =====
// Top level of the three-term recurrence checksum over a byte stream.
//
//   Channel | Ports                   | Contents
//   --------+-------------------------+-------------------------------------
//   input   | in_tvalid/tready/tdata  | tdata[7:0] data_byte; tlast is_last
//   result  | out_tvalid/tready/tdata | tdata[15:0] checksum
//
// Each transfer is registered on arrival in the input register and processed from there,
// so one byte is taken per cycle while no last byte stalls. out_tvalid rises from the result
// register once the last byte has passed the input register and been processed.
// The term update is combinational because the next byte needs the term just computed.
// Only a last byte stalls: while the previous checksum waits, it holds the input register
// and the input is not ready. Non-last bytes never wait for the result side.
// Reset (rst_n low, synchronous) empties both registers and starts a new message.
module three_term_recurrence_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] checksum
);
  import ttrc_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic [TERM_W-1:0] older_r;
  logic [TERM_W-1:0] older_nxt;
  logic [TERM_W-1:0] newer_r;
  logic [TERM_W-1:0] newer_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              start_r;
  logic              start_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [TERM_W-1:0] out_data_r;
  logic              out_free;
  logic              fire;
  logic              in_xfer;
  logic [TERM_W-1:0] step_term;
  logic [TERM_W-1:0] cur_term;

  // Handshake control: a registered byte is processed unless it ends a message and
  // the result register still holds a checksum that out_tready is not taking.
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || fire;
  assign in_xfer   = in_tvalid && in_tready;

  ttrc_step u_step (
    .data_byte  (s1_byte_r),
    .pos        (pos_r),
    .newer_term (newer_r),
    .older_term (older_r),
    .next_term  (step_term)
  );

  // The first byte of a message seeds the term; later bytes use the recurrence.
  assign cur_term = start_r ? (TERM_W'(s1_byte_r) + START_OFFSET) : step_term;

  // Next-state logic for the recurrence state and the result register.
  always_comb begin
    s1_valid_nxt  = in_xfer ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (fire) begin
      older_nxt = start_r ? TERM_W'(1) : newer_r;
      newer_nxt = cur_term;
      pos_nxt   = pos_r + POS_W'(1);
      start_nxt = 1'b0;
      if (s1_last_r) begin
        pos_nxt       = '0;
        start_nxt     = 1'b1;
        out_valid_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: input byte, the two terms and the result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    older_r <= older_nxt;
    newer_r <= newer_nxt;
    if (fire && s1_last_r) begin
      out_data_r <= cur_term;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
